// ===== rtl/mntm_pkg.sv =====
`default_nettype none

package mntm_pkg;

    // output count, settled by the fixed 2-bit index and 3-bit count fields
    localparam int NUM_OUTPUTS = 4;
    localparam int IDX_W       = 2;
    localparam int CNT_W       = 3;

    // field widths
    localparam int DATA_W  = 7;
    localparam int CHAN_W  = 5;
    localparam int LEN_W   = 16;
    localparam int LEVEL_W = 12;

    typedef logic [1:0]        t_act;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [LEN_W-1:0]  t_len;

    // pulse actions
    localparam t_act ACT_NONE  = 2'd0;
    localparam t_act ACT_START = 2'd1;
    localparam t_act ACT_END   = 2'd2;

    // request types
    localparam logic REQ_MIDI  = 1'b0;
    localparam logic REQ_LEARN = 1'b1;

    // value source modes
    localparam logic VSRC_VEL = 1'b0;
    localparam logic VSRC_CC  = 1'b1;

    // status byte upper nibbles
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CC       = 4'hB;

    // learned channel that matches every message channel
    localparam t_chan CHAN_ALL = 5'd16;

    localparam t_data DATA_MAX = 7'd127;

    // configuration register indexes
    localparam logic [1:0] CFG_VALUE_SOURCE = 2'd0;
    localparam logic [1:0] CFG_PULSE_MIN    = 2'd1;
    localparam logic [1:0] CFG_PULSE_MAX    = 2'd2;
    localparam logic [1:0] CFG_FLASH_LEN    = 2'd3;

    // register reset values
    localparam t_len PULSE_MIN_RST = 16'd1;
    localparam t_len PULSE_MAX_RST = 16'd100;
    localparam t_len FLASH_LEN_RST = 16'd100;

    // level scaling: (v * 516) >> 4
    localparam logic [15:0] LEVEL_MUL = 16'd516;

    // length span times velocity, at most 65535 * 126
    localparam int PROD_W  = 23;
    // divide by 127 as multiply by ceil(2^30 / 127), exact for products below 2^23
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_127 = 24'd8454661;

endpackage

`default_nettype wire

// ===== rtl/mntm_div127.sv =====
`default_nettype none

// quotient of a length span product by 127, by reciprocal multiply
module mntm_div127 (
    input  wire logic [mntm_pkg::PROD_W-1:0] i_prod,
    output logic      [mntm_pkg::LEN_W-1:0]  o_quot
);

    localparam int FULL_W = mntm_pkg::PROD_W + mntm_pkg::RECIP_W;

    logic [FULL_W-1:0] full;

    assign full   = FULL_W'(i_prod) * FULL_W'(mntm_pkg::RECIP_127);
    assign o_quot = full[mntm_pkg::RECIP_SHIFT +: mntm_pkg::LEN_W];

endmodule

`default_nettype wire

// ===== rtl/midi_note_trigger_mapper.sv =====
`default_nettype none

// MIDI note trigger mapper: each decoded MIDI message or learn request taken on
// the slave stream gives exactly one result on the master stream, holding a
// pulse action (none, start or end) for one of four outputs, an optional 12-bit
// level for an output, and the learn flag and learn counters after the message.
// The block is a three-register pipeline (input register, match/learn stage,
// result register): a message is taken every cycle while results drain, and
// its result passes through the match/learn stage register into the result
// register. The pulse length path registers the 16x7 span-times-velocity
// product before the divide by 127, done as a reciprocal multiply into the
// result register. Learned table entries and counters update as a message
// leaves the input register, so the next message already sees them.
// Configuration is written through the cfg port and is always ready; write it
// only while the pipeline is empty.
module midi_note_trigger_mapper (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,

    // message stream in
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // status_byte[7:0], midi_chan[11:8], first_data[18:12], second_data[25:19],
    // learn_on[26], zero fill [31:27]
    input  wire logic [31:0] i_s_axis_tdata,
    // req_type
    input  wire logic        i_s_axis_tuser,

    // result stream out
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // pulse_action[1:0], pulse_output[3:2], pulse_length[19:4], level_write[20],
    // level_output[22:21], level_value[34:23], learn_active[35],
    // notes_learned[38:36], ccs_learned[41:39], zero fill [47:42]
    output logic [47:0]      o_m_axis_tdata
);

    localparam int N     = mntm_pkg::NUM_OUTPUTS;
    localparam int IDX_W = mntm_pkg::IDX_W;
    localparam int CNT_W = mntm_pkg::CNT_W;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic               r_value_source;
    mntm_pkg::t_len     r_pulse_min;
    mntm_pkg::t_len     r_pulse_max;
    mntm_pkg::t_len     r_flash_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_source <= mntm_pkg::VSRC_VEL;
            r_pulse_min    <= mntm_pkg::PULSE_MIN_RST;
            r_pulse_max    <= mntm_pkg::PULSE_MAX_RST;
            r_flash_len    <= mntm_pkg::FLASH_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mntm_pkg::CFG_VALUE_SOURCE: r_value_source <= i_cfg_data[0];
                mntm_pkg::CFG_PULSE_MIN:    r_pulse_min    <= i_cfg_data;
                mntm_pkg::CFG_PULSE_MAX:    r_pulse_max    <= i_cfg_data;
                mntm_pkg::CFG_FLASH_LEN:    r_flash_len    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline flow control: each stage moves when the next one frees up
    // ---------------------------------------------------------------
    logic r_in_valid;
    logic r_s1_valid;
    logic r_out_valid;
    logic adv_out;
    logic adv_s1;
    logic adv_in;
    logic fire;

    assign adv_out = !r_out_valid || i_m_axis_tready;
    assign adv_s1  = !r_s1_valid || adv_out;
    assign adv_in  = !r_in_valid || adv_s1;
    // message leaves the input register and commits its state update
    assign fire    = r_in_valid && adv_s1;

    assign o_s_axis_tready = adv_in;
    assign o_m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (adv_s1) begin
                r_s1_valid <= r_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // ---------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------
    logic                r_in_req;
    logic [3:0]          r_in_kind;
    logic [3:0]          r_in_chan;
    mntm_pkg::t_data     r_in_d1;
    mntm_pkg::t_data     r_in_d2;
    logic                r_in_lon;

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && adv_in) begin
            r_in_req  <= i_s_axis_tuser;
            r_in_kind <= i_s_axis_tdata[7:4];
            r_in_chan <= i_s_axis_tdata[11:8];
            r_in_d1   <= i_s_axis_tdata[18:12];
            r_in_d2   <= i_s_axis_tdata[25:19];
            r_in_lon  <= i_s_axis_tdata[26];
        end
    end

    // ---------------------------------------------------------------
    // learned tables and learn state
    // ---------------------------------------------------------------
    mntm_pkg::t_data     r_note_num  [N];
    mntm_pkg::t_chan     r_note_chan [N];
    mntm_pkg::t_data     r_cc_num    [N];
    mntm_pkg::t_chan     r_cc_chan   [N];
    logic                r_learn_flag;
    logic [CNT_W-1:0]    r_note_count;
    logic [CNT_W-1:0]    r_cc_count;

    // ---------------------------------------------------------------
    // parallel compare against all four entries
    // ---------------------------------------------------------------
    mntm_pkg::t_chan     msg_chan;
    logic                note_hit;
    logic [IDX_W-1:0]    note_idx;
    logic                cc_hit;
    logic [IDX_W-1:0]    cc_idx;
    logic                note_dup;
    logic                cc_dup;

    assign msg_chan = {1'b0, r_in_chan};

    always_comb begin
        note_hit = 1'b0;
        note_idx = '0;
        cc_hit   = 1'b0;
        cc_idx   = '0;
        note_dup = 1'b0;
        cc_dup   = 1'b0;
        // walk downward so the lowest matching output wins
        for (int i = N - 1; i >= 0; i--) begin
            if (r_note_num[i] == r_in_d1 &&
                (r_note_chan[i] == mntm_pkg::CHAN_ALL || r_note_chan[i] == msg_chan)) begin
                note_hit = 1'b1;
                note_idx = IDX_W'(i);
            end
            if (r_cc_num[i] == r_in_d1 &&
                (r_cc_chan[i] == mntm_pkg::CHAN_ALL || r_cc_chan[i] == msg_chan)) begin
                cc_hit = 1'b1;
                cc_idx = IDX_W'(i);
            end
        end
        // duplicates only among entries learned in this session
        for (int i = 0; i < N; i++) begin
            if (CNT_W'(i) < r_note_count && r_note_num[i] == r_in_d1 &&
                r_note_chan[i] == msg_chan) begin
                note_dup = 1'b1;
            end
            if (CNT_W'(i) < r_cc_count && r_cc_num[i] == r_in_d1 &&
                r_cc_chan[i] == msg_chan) begin
                cc_dup = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // level and pulse length span
    // ---------------------------------------------------------------
    logic [15:0]               lvl_prod;
    mntm_pkg::t_len            lvl_value;
    logic                      span_up;
    mntm_pkg::t_len            span;
    mntm_pkg::t_len            vel_base;
    logic [mntm_pkg::PROD_W-1:0] vel_prod;

    assign lvl_prod  = 16'(r_in_d2) * mntm_pkg::LEVEL_MUL;
    assign lvl_value = 16'(lvl_prod[15:4]);
    assign span_up   = r_pulse_max >= r_pulse_min;
    assign span      = span_up ? (r_pulse_max - r_pulse_min) : (r_pulse_min - r_pulse_max);

    always_comb begin
        // both velocity endpoints give the register value exactly
        if (r_in_d2 == '0) begin
            vel_base = r_pulse_min;
            vel_prod = '0;
        end else if (r_in_d2 == mntm_pkg::DATA_MAX) begin
            vel_base = r_pulse_max;
            vel_prod = '0;
        end else begin
            vel_base = r_pulse_min;
            vel_prod = mntm_pkg::PROD_W'(span) * mntm_pkg::PROD_W'(r_in_d2);
        end
    end

    // ---------------------------------------------------------------
    // message decode and learn sequencing
    // ---------------------------------------------------------------
    logic                        n_learn_flag;
    logic [CNT_W-1:0]            n_note_count;
    logic [CNT_W-1:0]            n_cc_count;
    logic                        note_we;
    logic                        cc_we;
    logic [IDX_W-1:0]            note_k;
    logic [IDX_W-1:0]            cc_k;

    mntm_pkg::t_act              n_s1_act;
    logic [IDX_W-1:0]            n_s1_pout;
    mntm_pkg::t_len              n_s1_base;
    logic [mntm_pkg::PROD_W-1:0] n_s1_prod;
    logic                        n_s1_up;
    logic                        n_s1_lw;
    logic [IDX_W-1:0]            n_s1_lout;
    logic [mntm_pkg::LEVEL_W-1:0] n_s1_lval;

    assign note_k = r_note_count[IDX_W-1:0];
    assign cc_k   = r_cc_count[IDX_W-1:0];

    always_comb begin
        n_learn_flag = r_learn_flag;
        n_note_count = r_note_count;
        n_cc_count   = r_cc_count;
        note_we      = 1'b0;
        cc_we        = 1'b0;
        n_s1_act     = mntm_pkg::ACT_NONE;
        n_s1_pout    = '0;
        n_s1_base    = '0;
        n_s1_prod    = '0;
        n_s1_up      = 1'b1;
        n_s1_lw      = 1'b0;
        n_s1_lout    = '0;
        n_s1_lval    = '0;

        if (r_in_req == mntm_pkg::REQ_LEARN) begin
            n_learn_flag = r_in_lon;
            if (r_in_lon) begin
                n_note_count = '0;
                n_cc_count   = '0;
            end
        end else if (r_learn_flag) begin
            if (r_in_kind == mntm_pkg::KIND_NOTE_ON && r_note_count < CNT_W'(N)) begin
                if (!note_dup) begin
                    // assign next output and flash it
                    note_we      = 1'b1;
                    n_s1_act     = mntm_pkg::ACT_START;
                    n_s1_pout    = note_k;
                    n_s1_base    = r_flash_len;
                    n_note_count = r_note_count + CNT_W'(1);
                    if (note_k == IDX_W'(N - 1) && r_value_source == mntm_pkg::VSRC_VEL) begin
                        n_learn_flag = 1'b0;
                    end
                end
            end else if (r_in_kind == mntm_pkg::KIND_CC &&
                         r_value_source == mntm_pkg::VSRC_CC &&
                         r_note_count == CNT_W'(N) && r_cc_count < CNT_W'(N)) begin
                if (!cc_dup) begin
                    cc_we      = 1'b1;
                    n_s1_act   = mntm_pkg::ACT_START;
                    n_s1_pout  = cc_k;
                    n_s1_base  = r_flash_len;
                    n_cc_count = r_cc_count + CNT_W'(1);
                    if (cc_k == IDX_W'(N - 1)) begin
                        n_learn_flag = 1'b0;
                    end
                end
            end
        end else if (r_in_kind == mntm_pkg::KIND_NOTE_ON) begin
            if (note_hit) begin
                if (r_value_source == mntm_pkg::VSRC_VEL) begin
                    n_s1_lw   = 1'b1;
                    n_s1_lout = note_idx;
                    n_s1_lval = lvl_value[mntm_pkg::LEVEL_W-1:0];
                end
                n_s1_pout = note_idx;
                // note-on with zero velocity acts as note-off
                if (r_in_d2 != '0) begin
                    n_s1_act  = mntm_pkg::ACT_START;
                    n_s1_base = vel_base;
                    n_s1_prod = vel_prod;
                    n_s1_up   = span_up;
                end else begin
                    n_s1_act = mntm_pkg::ACT_END;
                end
            end
        end else if (r_in_kind == mntm_pkg::KIND_NOTE_OFF) begin
            if (note_hit) begin
                n_s1_act  = mntm_pkg::ACT_END;
                n_s1_pout = note_idx;
            end
        end else if (r_in_kind == mntm_pkg::KIND_CC &&
                     r_value_source == mntm_pkg::VSRC_CC) begin
            if (cc_hit) begin
                n_s1_lw   = 1'b1;
                n_s1_lout = cc_idx;
                n_s1_lval = lvl_value[mntm_pkg::LEVEL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_note_num[i]  <= '0;
                r_note_chan[i] <= mntm_pkg::CHAN_ALL;
                r_cc_num[i]    <= '0;
                r_cc_chan[i]   <= mntm_pkg::CHAN_ALL;
            end
            r_learn_flag <= 1'b0;
            r_note_count <= '0;
            r_cc_count   <= '0;
        end else if (fire) begin
            if (note_we) begin
                r_note_num[note_k]  <= r_in_d1;
                r_note_chan[note_k] <= msg_chan;
            end
            if (cc_we) begin
                r_cc_num[cc_k]  <= r_in_d1;
                r_cc_chan[cc_k] <= msg_chan;
            end
            r_learn_flag <= n_learn_flag;
            r_note_count <= n_note_count;
            r_cc_count   <= n_cc_count;
        end
    end

    // ---------------------------------------------------------------
    // stage 1 register
    // ---------------------------------------------------------------
    mntm_pkg::t_act              r_s1_act;
    logic [IDX_W-1:0]            r_s1_pout;
    mntm_pkg::t_len              r_s1_base;
    logic [mntm_pkg::PROD_W-1:0] r_s1_prod;
    logic                        r_s1_up;
    logic                        r_s1_lw;
    logic [IDX_W-1:0]            r_s1_lout;
    logic [mntm_pkg::LEVEL_W-1:0] r_s1_lval;
    logic                        r_s1_flag;
    logic [CNT_W-1:0]            r_s1_ncnt;
    logic [CNT_W-1:0]            r_s1_ccnt;

    always_ff @(posedge i_clk) begin
        if (adv_s1) begin
            r_s1_act  <= n_s1_act;
            r_s1_pout <= n_s1_pout;
            r_s1_base <= n_s1_base;
            r_s1_prod <= n_s1_prod;
            r_s1_up   <= n_s1_up;
            r_s1_lw   <= n_s1_lw;
            r_s1_lout <= n_s1_lout;
            r_s1_lval <= n_s1_lval;
            // learn status reported after this message
            r_s1_flag <= n_learn_flag;
            r_s1_ncnt <= n_note_count;
            r_s1_ccnt <= n_cc_count;
        end
    end

    // ---------------------------------------------------------------
    // divide the span product by 127 and finish the length
    // ---------------------------------------------------------------
    mntm_pkg::t_len quot;
    mntm_pkg::t_len n_out_len;

    mntm_div127 u_div127 (
        .i_prod (r_s1_prod),
        .o_quot (quot)
    );

    // rising span adds to pulse_min, falling span subtracts from it
    assign n_out_len = r_s1_up ? (r_s1_base + quot) : (r_s1_base - quot);

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    mntm_pkg::t_act               r_out_act;
    logic [IDX_W-1:0]             r_out_pout;
    mntm_pkg::t_len               r_out_len;
    logic                         r_out_lw;
    logic [IDX_W-1:0]             r_out_lout;
    logic [mntm_pkg::LEVEL_W-1:0] r_out_lval;
    logic                         r_out_flag;
    logic [CNT_W-1:0]             r_out_ncnt;
    logic [CNT_W-1:0]             r_out_ccnt;

    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_out_act  <= r_s1_act;
            r_out_pout <= r_s1_pout;
            r_out_len  <= n_out_len;
            r_out_lw   <= r_s1_lw;
            r_out_lout <= r_s1_lout;
            r_out_lval <= r_s1_lval;
            r_out_flag <= r_s1_flag;
            r_out_ncnt <= r_s1_ncnt;
            r_out_ccnt <= r_s1_ccnt;
        end
    end

    assign o_m_axis_tdata = {6'd0, r_out_ccnt, r_out_ncnt, r_out_flag, r_out_lval,
                             r_out_lout, r_out_lw, r_out_len, r_out_pout, r_out_act};

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mntm_pkg::*;

    // one message as it enters the block, req_type travels on tuser
    typedef struct packed {
        logic       req;
        logic       learn_on;
        t_data      value;
        t_data      note;
        logic [3:0] chan;
        logic [7:0] status;
    } t_stim_item;

    // result layout, lowest bits last, matching the master tdata bus
    typedef struct packed {
        logic [5:0]  fill;
        logic [2:0]  ccs;
        logic [2:0]  notes;
        logic        learning;
        logic [11:0] level;
        logic [1:0]  level_out;
        logic        level_wr;
        t_len        pulse_len;
        logic [1:0]  pulse_out;
        t_act        act;
    } t_trig_result;

    // predicts the trigger, level and learn outputs of every message
    class trigger_map_tracker;
        logic             vsrc;
        t_len             len_min;
        t_len             len_max;
        t_len             flash_len;
        t_data            note_num [NUM_OUTPUTS];
        t_chan            note_chn [NUM_OUTPUTS];
        t_data            cc_num   [NUM_OUTPUTS];
        t_chan            cc_chn   [NUM_OUTPUTS];
        logic             learning;
        logic [CNT_W-1:0] notes_done;
        logic [CNT_W-1:0] ccs_done;
        t_trig_result     pending_results [$];
        int               errors;
        int               n_start;
        int               n_end;
        int               n_level;
        int               n_flash;
        int               n_checked;

        function new();
            vsrc      = VSRC_VEL;
            len_min   = PULSE_MIN_RST;
            len_max   = PULSE_MAX_RST;
            flash_len = FLASH_LEN_RST;
            for (int i = 0; i < NUM_OUTPUTS; i++) begin
                note_num[i] = '0;
                note_chn[i] = CHAN_ALL;
                cc_num[i]   = '0;
                cc_chn[i]   = CHAN_ALL;
            end
            learning   = 1'b0;
            notes_done = '0;
            ccs_done   = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_VALUE_SOURCE: vsrc      = val[0];
                CFG_PULSE_MIN:    len_min   = val;
                CFG_PULSE_MAX:    len_max   = val;
                CFG_FLASH_LEN:    flash_len = val;
                default: ;
            endcase
        endfunction

        // first output listening to this number on this channel
        function int find_slot(bit is_cc, t_data n, logic [3:0] ch);
            for (int i = 0; i < NUM_OUTPUTS; i++) begin
                if (is_cc ? (cc_num[i] == n && (cc_chn[i] == CHAN_ALL || cc_chn[i] == {1'b0, ch}))
                          : (note_num[i] == n &&
                             (note_chn[i] == CHAN_ALL || note_chn[i] == {1'b0, ch})))
                    return i;
            end
            return NUM_OUTPUTS;
        endfunction

        // exact number and channel already taken in this learn session
        function bit seen_in_session(bit is_cc, int cnt, t_data n, logic [3:0] ch);
            for (int i = 0; i < cnt; i++) begin
                if (is_cc ? (cc_num[i] == n && cc_chn[i] == {1'b0, ch})
                          : (note_num[i] == n && note_chn[i] == {1'b0, ch}))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // linear between the two lengths, endpoints exact, also falling
        function t_len pulse_len_for(t_data v);
            int unsigned lo;
            int unsigned hi;
            lo = len_min;
            hi = len_max;
            if (v == '0)
                return len_min;
            if (v == DATA_MAX)
                return len_max;
            if (hi >= lo)
                return t_len'(lo + ((hi - lo) * v) / DATA_MAX);
            return t_len'(lo - ((lo - hi) * v) / DATA_MAX);
        endfunction

        function logic [11:0] level_of(t_data v);
            return 12'((int'(v) * int'(LEVEL_MUL)) >> 4);
        endfunction

        function void take_message(t_stim_item m);
            t_trig_result r;
            logic [3:0]   kind;
            int           k;
            r    = '0;
            kind = m.status[7:4];
            if (m.req == REQ_LEARN) begin
                learning = m.learn_on;
                if (m.learn_on) begin
                    notes_done = '0;
                    ccs_done   = '0;
                end
            end else if (learning) begin
                if (kind == KIND_NOTE_ON && notes_done < NUM_OUTPUTS) begin
                    k = notes_done;
                    if (!seen_in_session(1'b0, k, m.note, m.chan)) begin
                        r.act       = ACT_START;
                        r.pulse_out = 2'(k);
                        r.pulse_len = flash_len;
                        note_num[k] = m.note;
                        note_chn[k] = {1'b0, m.chan};
                        notes_done  = 3'(k + 1);
                        // velocity mode has nothing left to learn after the notes
                        if (k == NUM_OUTPUTS - 1 && vsrc == VSRC_VEL)
                            learning = 1'b0;
                        n_flash++;
                    end
                end else if (kind == KIND_CC && vsrc == VSRC_CC &&
                             notes_done == NUM_OUTPUTS && ccs_done < NUM_OUTPUTS) begin
                    k = ccs_done;
                    if (!seen_in_session(1'b1, k, m.note, m.chan)) begin
                        r.act       = ACT_START;
                        r.pulse_out = 2'(k);
                        r.pulse_len = flash_len;
                        cc_num[k]   = m.note;
                        cc_chn[k]   = {1'b0, m.chan};
                        ccs_done    = 3'(k + 1);
                        if (k == NUM_OUTPUTS - 1)
                            learning = 1'b0;
                        n_flash++;
                    end
                end
            end else if (kind == KIND_NOTE_ON) begin
                k = find_slot(1'b0, m.note, m.chan);
                if (k < NUM_OUTPUTS) begin
                    if (vsrc == VSRC_VEL) begin
                        r.level_wr  = 1'b1;
                        r.level_out = 2'(k);
                        r.level     = level_of(m.value);
                    end
                    r.pulse_out = 2'(k);
                    if (m.value != '0) begin
                        r.act       = ACT_START;
                        r.pulse_len = pulse_len_for(m.value);
                    end else begin
                        r.act = ACT_END;
                    end
                end
            end else if (kind == KIND_NOTE_OFF) begin
                k = find_slot(1'b0, m.note, m.chan);
                if (k < NUM_OUTPUTS) begin
                    r.act       = ACT_END;
                    r.pulse_out = 2'(k);
                end
            end else if (kind == KIND_CC && vsrc == VSRC_CC) begin
                k = find_slot(1'b1, m.note, m.chan);
                if (k < NUM_OUTPUTS) begin
                    r.level_wr  = 1'b1;
                    r.level_out = 2'(k);
                    r.level     = level_of(m.value);
                end
            end
            r.learning = learning;
            r.notes    = notes_done;
            r.ccs      = ccs_done;
            if (r.act == ACT_START)
                n_start++;
            if (r.act == ACT_END)
                n_end++;
            if (r.level_wr)
                n_level++;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string what, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
            end
        endfunction

        function void check_result(logic [47:0] d);
            t_trig_result got;
            t_trig_result want;
            got = d;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result transaction with nothing expected, expected none, actual %h",
                         $time, d);
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            compare_field("pulse_action", want.act, got.act);
            compare_field("pulse_output", want.pulse_out, got.pulse_out);
            compare_field("pulse_length", want.pulse_len, got.pulse_len);
            compare_field("level_write", want.level_wr, got.level_wr);
            compare_field("level_output", want.level_out, got.level_out);
            compare_field("level_value", want.level, got.level);
            compare_field("learn_active", want.learning, got.learning);
            compare_field("notes_learned", want.notes, got.notes);
            compare_field("ccs_learned", want.ccs, got.ccs);
            compare_field("zero fill", want.fill, got.fill);
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index     = CFG_VALUE_SOURCE;
    logic [15:0] i_cfg_data      = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;
    logic        i_s_axis_tuser  = REQ_MIDI;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;

    trigger_map_tracker tracker = new();

    // idle percentages per side, receiver hold-off counted down below
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold     = 0;
    int n_sent      = 0;
    int n_settings  = 1;

    midi_note_trigger_mapper dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random back-pressure, or a long hold-off while rx_hold runs down
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // every result transaction is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_result(o_m_axis_tdata);
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_data pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return DATA_MAX;
            2:       return 7'd1;
            3:       return DATA_MAX - 7'd1;
            default: return 7'($urandom);
        endcase
    endfunction

    // status low nibble and the learn bit are don't-care for a message
    function automatic t_stim_item make_msg(logic [3:0] kind, logic [3:0] ch, t_data n,
                                            t_data v);
        t_stim_item m;
        m.req      = REQ_MIDI;
        m.status   = {kind, 4'($urandom)};
        m.chan     = ch;
        m.note     = n;
        m.value    = v;
        m.learn_on = 1'($urandom);
        return m;
    endfunction

    function automatic t_stim_item learn_req(logic on);
        t_stim_item m;
        m          = 28'($urandom);
        m.req      = REQ_LEARN;
        m.learn_on = on;
        return m;
    endfunction

    // any field pattern, now and then a learn request
    function automatic t_stim_item noise_msg();
        t_stim_item m;
        m     = 28'($urandom);
        m.req = ($urandom_range(7) == 0) ? REQ_LEARN : REQ_MIDI;
        return m;
    endfunction

    // message aimed at a learned output, sometimes on a foreign channel
    function automatic t_stim_item play_msg();
        int         k;
        int         sel;
        logic [3:0] kind;
        t_data      n;
        t_chan      c;
        logic [3:0] ch;
        k   = $urandom_range(NUM_OUTPUTS - 1);
        sel = $urandom_range(99);
        if (sel < 55)
            kind = KIND_NOTE_ON;
        else if (sel < 75)
            kind = KIND_NOTE_OFF;
        else
            kind = KIND_CC;
        if (kind == KIND_CC) begin
            n = tracker.cc_num[k];
            c = tracker.cc_chn[k];
        end else begin
            n = tracker.note_num[k];
            c = tracker.note_chn[k];
        end
        ch = (c == CHAN_ALL || $urandom_range(9) == 0) ? 4'($urandom) : c[3:0];
        return make_msg(kind, ch, n, pick_value());
    endfunction

    // offer one message and wait for its transaction
    task automatic send_msg(input t_stim_item m);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= m.req;
        i_s_axis_tdata  <= {5'b0, m.learn_on, m.value, m.note, m.chan, m.status};
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.take_message(m);
        n_sent++;
    endtask

    // stop offering and let every predicted result come out
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_results.size() != 0);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic vs, input t_len lo, input t_len hi, input t_len fl);
        wait_idle();
        cfg_write(CFG_VALUE_SOURCE, {15'b0, vs});
        cfg_write(CFG_PULSE_MIN, lo);
        cfg_write(CFG_PULSE_MAX, hi);
        cfg_write(CFG_FLASH_LEN, fl);
        n_settings++;
    endtask

    // full learn session: notes, then controllers in cc mode, with
    // duplicates and out-of-order messages mixed in
    task automatic learn_session();
        int guard;
        int j;
        int sel;
        send_msg(learn_req(1'b1));
        guard = 0;
        while (tracker.learning && tracker.notes_done < NUM_OUTPUTS && guard < 24) begin
            guard++;
            sel = $urandom_range(9);
            if (sel == 0) begin
                send_msg(make_msg(KIND_NOTE_OFF, 4'($urandom), 7'($urandom), pick_value()));
            end else if (sel == 1) begin
                // controllers are not taken before the notes are done
                send_msg(make_msg(KIND_CC, 4'($urandom), 7'($urandom), pick_value()));
            end else if (sel == 2 && tracker.notes_done != 0) begin
                j = $urandom_range(tracker.notes_done - 1);
                send_msg(make_msg(KIND_NOTE_ON, tracker.note_chn[j][3:0], tracker.note_num[j],
                                  pick_value()));
            end else begin
                send_msg(make_msg(KIND_NOTE_ON, 4'($urandom), 7'($urandom), pick_value()));
            end
        end
        while (tracker.learning && tracker.vsrc == VSRC_CC &&
               tracker.ccs_done < NUM_OUTPUTS && guard < 48) begin
            guard++;
            sel = $urandom_range(9);
            if (sel == 0) begin
                send_msg(make_msg(KIND_NOTE_ON, 4'($urandom), 7'($urandom), pick_value()));
            end else if (sel == 1 && tracker.ccs_done != 0) begin
                j = $urandom_range(tracker.ccs_done - 1);
                send_msg(make_msg(KIND_CC, tracker.cc_chn[j][3:0], tracker.cc_num[j],
                                  pick_value()));
            end else begin
                send_msg(make_msg(KIND_CC, 4'($urandom), 7'($urandom), pick_value()));
            end
        end
    endtask

    // mostly playing learned outputs, some learn sessions, some noise
    task automatic make_traffic(input int count);
        int stop_at;
        int sel;
        stop_at = n_sent + count;
        while (n_sent < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 10)
                learn_session();
            else if (sel < 82)
                send_msg(play_msg());
            else
                send_msg(noise_msg());
        end
    endtask

    initial begin
        int guard;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles lightly, receiver heavily
        tx_idle_pct = 20;
        rx_idle_pct = 73;

        // table after reset listens to note 0 on every channel
        send_msg(make_msg(KIND_NOTE_ON, 4'd9, 7'd0, 7'd64));
        send_msg(make_msg(KIND_NOTE_OFF, 4'd3, 7'd0, 7'd0));
        // learn in velocity mode, note-off and controller ignored
        send_msg(learn_req(1'b1));
        send_msg(make_msg(KIND_NOTE_OFF, 4'd0, 7'd5, 7'd10));
        send_msg(make_msg(KIND_CC, 4'd0, 7'd5, 7'd10));
        send_msg(make_msg(KIND_NOTE_ON, 4'd0, 7'd0, 7'd1));
        // duplicate of the first assignment is rejected
        send_msg(make_msg(KIND_NOTE_ON, 4'd0, 7'd0, 7'd90));
        send_msg(make_msg(KIND_NOTE_ON, 4'd15, DATA_MAX, DATA_MAX));
        send_msg(make_msg(KIND_NOTE_ON, 4'd5, 7'd60, 7'd0));
        // same note on another channel is a new assignment, last one ends learn
        send_msg(make_msg(KIND_NOTE_ON, 4'd0, 7'd60, 7'd33));
        // playing: top length endpoint, velocity one, zero velocity and note-off end
        send_msg(make_msg(KIND_NOTE_ON, 4'd0, 7'd0, DATA_MAX));
        send_msg(make_msg(KIND_NOTE_ON, 4'd15, DATA_MAX, 7'd1));
        send_msg(make_msg(KIND_NOTE_ON, 4'd5, 7'd60, 7'd0));
        send_msg(make_msg(KIND_NOTE_OFF, 4'd0, 7'd60, DATA_MAX));
        send_msg(make_msg(KIND_NOTE_ON, 4'd0, 7'd1, 7'd50));
        // controller in velocity mode and foreign status nibbles
        send_msg(make_msg(KIND_CC, 4'd0, 7'd0, DATA_MAX));
        send_msg(make_msg(4'hF, 4'd0, 7'd0, 7'd64));
        send_msg(make_msg(4'hA, 4'd15, DATA_MAX, 7'd64));
        send_msg(learn_req(1'b0));
        make_traffic(150);

        // cc mode with all lengths at their extremes, minimum above maximum
        set_regs(VSRC_CC, 16'hFFFF, 16'h0000, 16'hFFFF);
        make_traffic(40);
        // long receiver hold-off while messages keep coming, fills the pipeline
        rx_hold = 400;
        make_traffic(135);

        // sender idles heavily, receiver lightly
        tx_idle_pct = 73;
        rx_idle_pct = 20;
        set_regs(VSRC_VEL, 16'h0000, 16'hFFFF, 16'h0000);
        make_traffic(175);

        // stuck learn: notes done in cc mode, then switched to velocity mode
        set_regs(VSRC_CC, 16'($urandom), 16'($urandom), 16'($urandom));
        send_msg(learn_req(1'b1));
        while (tracker.notes_done < NUM_OUTPUTS)
            send_msg(make_msg(KIND_NOTE_ON, 4'($urandom), 7'($urandom), pick_value()));
        wait_idle();
        cfg_write(CFG_VALUE_SOURCE, {15'b0, VSRC_VEL});
        send_msg(make_msg(KIND_NOTE_ON, 4'($urandom), 7'($urandom), pick_value()));
        send_msg(make_msg(KIND_CC, 4'($urandom), 7'($urandom), pick_value()));
        send_msg(make_msg(KIND_NOTE_OFF, 4'($urandom), 7'($urandom), pick_value()));
        send_msg(learn_req(1'b0));
        make_traffic(170);

        // no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_regs(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        make_traffic(175);
        set_regs(VSRC_CC, 16'($urandom), 16'($urandom), 16'($urandom));
        make_traffic(80);
        // sender pauses until the pipeline has drained
        wait_idle();
        make_traffic(95);

        // drain, then wait on to catch anything surplus
        i_s_axis_tvalid <= 1'b0;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (tracker.pending_results.size() != 0 && guard < 5000);
        repeat (8) @(posedge i_clk);
        if (tracker.pending_results.size() != 0) begin
            tracker.errors += tracker.pending_results.size();
            $display("%0t: results missing, expected %0d more, actual 0", $time,
                     tracker.pending_results.size());
        end

        $display("%0d messages, %0d results checked: %0d pulse starts, %0d ends, %0d levels",
                 n_sent, tracker.n_checked, tracker.n_start, tracker.n_end, tracker.n_level);
        $display("%0d learn assignments over %0d register settings, with hold-off and drains",
                 tracker.n_flash, n_settings);
        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
